/* sv/bounded_top_k_max_heap_top_assert.svh */
// Assertion macros for the bounded top-k heap.
// Both sample on clock and are switched off while reset is high.
`ifndef BOUNDED_TOP_K_MAX_HEAP_TOP_ASSERT_SVH
`define BOUNDED_TOP_K_MAX_HEAP_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTKH_AST_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BTKH_AST_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/btkh_pkg.sv */
`default_nettype none
package btkh_pkg;

   // width of entry counts, capacity and held_count
   localparam int CNT_W = 6;
   // child index width, wide enough for 2*63+2
   localparam int CHW = CNT_W + 2;

   localparam logic [CNT_W-1:0] CAP_RESET = 6'd32;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DRAIN  = 1'b1;

   typedef logic [CNT_W-1:0] count_type;

endpackage
`default_nettype wire

/* sv/bounded_top_k_max_heap_top.sv */
// Channel   | Ports                                     | Handshake
// request   | start, busy, req_*                        | taken when start && !busy
// result    | rsp_valid, rsp_*                          | one-cycle strobe, no back-pressure
// config    | csr_write_enable, csr_write_data          | written on enable, no wait
//
// Insert while filling moves the pair up, reading a parent per step, until it stops below
// the root or reaches it; replacing the root moves it down a level per compare until it
// stops on a compare or at a leaf; a dropped pair goes straight to the result. Drain
// returns each held entry, last slot first, or one empty result; one heap access a cycle.
// Reset (synchronous) empties the heap and sets capacity to 32; no clearing pass.
// Results cannot be stalled; busy falls in the cycle that carries the last result.
`default_nettype none
module bounded_top_k_max_heap_top
   import btkh_pkg::*;
#(
   parameter int MAX_K      = 32,
   parameter int DIST_WIDTH = 32,
   parameter int ID_WIDTH   = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output      logic                  busy,
   input  wire logic                  req_operation,
   input  wire logic [DIST_WIDTH-1:0] req_distance,
   input  wire logic [ID_WIDTH-1:0]   req_record_id,
   output      logic                  rsp_valid,
   output      logic                  rsp_is_record,
   output      logic [DIST_WIDTH-1:0] rsp_out_distance,
   output      logic [ID_WIDTH-1:0]   rsp_out_record_id,
   output      logic                  rsp_kept,
   output      logic [CNT_W-1:0]      rsp_held_count,
   output      logic                  rsp_last,
   input  wire logic                  csr_write_enable,
   input  wire logic [CNT_W-1:0]      csr_write_data
);

   localparam int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int EW    = DIST_WIDTH + ID_WIDTH;
   localparam count_type KMAX_CNT = (MAX_K > 63) ? count_type'(63) : count_type'(MAX_K);

   count_type        cap_ff;
   count_type        k_eff;
   logic             mem_we, mem_re;
   logic [IDX_W-1:0] mem_waddr, mem_raddr;
   logic [EW-1:0]    mem_wdata, mem_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_write_enable) begin
         cap_ff <= csr_write_data;
      end
   end

   // zero acts as one, anything above the heap depth or 63, whichever is less, as that limit
   always_comb begin
      priority if (cap_ff == '0) begin
         k_eff = count_type'(1);
      end else if (cap_ff > KMAX_CNT) begin
         k_eff = KMAX_CNT;
      end else begin
         k_eff = cap_ff;
      end
   end

   btkh_ctrl #(
      .MAX_K      (MAX_K),
      .DIST_WIDTH (DIST_WIDTH),
      .ID_WIDTH   (ID_WIDTH),
      .IDX_W      (IDX_W),
      .EW         (EW)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .k_eff             (k_eff),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_distance      (req_distance),
      .req_record_id     (req_record_id),
      .rsp_valid         (rsp_valid),
      .rsp_is_record     (rsp_is_record),
      .rsp_out_distance  (rsp_out_distance),
      .rsp_out_record_id (rsp_out_record_id),
      .rsp_kept          (rsp_kept),
      .rsp_held_count    (rsp_held_count),
      .rsp_last          (rsp_last),
      .mem_we            (mem_we),
      .mem_waddr         (mem_waddr),
      .mem_wdata         (mem_wdata),
      .mem_re            (mem_re),
      .mem_raddr         (mem_raddr),
      .mem_rdata         (mem_rdata)
   );

   btkh_mem #(
      .DEPTH  (MAX_K),
      .ADDR_W (IDX_W),
      .DATA_W (EW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

endmodule
`default_nettype wire

/* sv/btkh_mem.sv */
`default_nettype none
module btkh_mem
   import btkh_pkg::*;
#(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5,
   parameter int DATA_W = 64
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* sv/btkh_ctrl.sv */
`default_nettype none
`include "bounded_top_k_max_heap_top_assert.svh"
module btkh_ctrl
   import btkh_pkg::*;
#(
   parameter int MAX_K      = 32,
   parameter int DIST_WIDTH = 32,
   parameter int ID_WIDTH   = 32,
   parameter int IDX_W      = 5,
   parameter int EW         = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire count_type             k_eff,
   input  wire logic                  start,
   output      logic                  busy,
   input  wire logic                  req_operation,
   input  wire logic [DIST_WIDTH-1:0] req_distance,
   input  wire logic [ID_WIDTH-1:0]   req_record_id,
   output      logic                  rsp_valid,
   output      logic                  rsp_is_record,
   output      logic [DIST_WIDTH-1:0] rsp_out_distance,
   output      logic [ID_WIDTH-1:0]   rsp_out_record_id,
   output      logic                  rsp_kept,
   output      count_type             rsp_held_count,
   output      logic                  rsp_last,
   output      logic                  mem_we,
   output      logic [IDX_W-1:0]      mem_waddr,
   output      logic [EW-1:0]         mem_wdata,
   output      logic                  mem_re,
   output      logic [IDX_W-1:0]      mem_raddr,
   input  wire logic [EW-1:0]         mem_rdata
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_UP_RD  = 4'd1;
   localparam logic [3:0] S_UP_CMP = 4'd2;
   localparam logic [3:0] S_UP_FIN = 4'd3;
   localparam logic [3:0] S_DN_RDL = 4'd4;
   localparam logic [3:0] S_DN_RDR = 4'd5;
   localparam logic [3:0] S_DN_CMP = 4'd6;
   localparam logic [3:0] S_DR_RD  = 4'd7;
   localparam logic [3:0] S_DR_OUT = 4'd8;
   localparam logic [3:0] S_RESP   = 4'd9;

   localparam count_type HELD_MAX = (MAX_K > 63) ? count_type'(63) : count_type'(MAX_K);

   logic [3:0]            state_ff, state_in;
   count_type             held_ff, held_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic [EW-1:0]         x_ff, x_in;
   logic [EW-1:0]         left_ff, left_in;
   logic                  kept_ff, kept_in;
   logic [EW-1:0]         root_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_is_record_ff, rsp_is_record_in;
   logic [EW-1:0]         rsp_entry_ff, rsp_entry_in;
   logic                  rsp_kept_ff, rsp_kept_in;
   count_type             rsp_held_count_ff, rsp_held_count_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [DIST_WIDTH-1:0] x_d, rd_d, left_d, child_d;
   logic [IDX_W-1:0]      parent_idx, child_idx;
   logic [CHW-1:0]        left_w, right_w;
   logic                  has_left, has_right, right_sel;
   logic [EW-1:0]         child_entry;
   count_type             held_dec;
   logic                  accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   assign x_d    = x_ff[EW-1:ID_WIDTH];
   assign rd_d   = mem_rdata[EW-1:ID_WIDTH];
   assign left_d = left_ff[EW-1:ID_WIDTH];

   assign parent_idx = (pos_ff - IDX_W'(1)) >> 1;
   assign left_w     = (CHW'(pos_ff) << 1) | CHW'(1);
   assign right_w    = left_w + CHW'(1);
   assign has_left   = left_w < CHW'(held_ff);
   assign has_right  = right_w < CHW'(held_ff);
   // larger child, left on a tie
   assign right_sel   = has_right && (left_d < rd_d);
   assign child_idx   = right_sel ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];
   assign child_entry = right_sel ? mem_rdata : left_ff;
   assign child_d     = child_entry[EW-1:ID_WIDTH];
   assign held_dec    = held_ff - count_type'(1);

   // The moving pair is kept in x_ff and only written once its slot is known;
   // every read is issued in a later state than the write before it, so
   // no access to the same slot overlaps.
   always_comb begin
      state_in          = state_ff;
      held_in           = held_ff;
      pos_in            = pos_ff;
      x_in              = x_ff;
      left_in           = left_ff;
      kept_in           = kept_ff;
      mem_we            = 1'b0;
      mem_waddr         = pos_ff;
      mem_wdata         = x_ff;
      mem_re            = 1'b0;
      mem_raddr         = '0;
      rsp_valid_in      = 1'b0;
      rsp_is_record_in  = 1'b0;
      rsp_entry_in      = '0;
      rsp_kept_in       = 1'b0;
      rsp_held_count_in = held_ff;
      rsp_last_in       = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               x_in    = {req_distance, req_record_id};
               kept_in = 1'b0;
               if (req_operation == OP_INSERT) begin
                  priority if (held_ff < k_eff) begin
                     pos_in   = held_ff[IDX_W-1:0];
                     held_in  = held_ff + count_type'(1);
                     kept_in  = 1'b1;
                     state_in = (held_ff == '0) ? S_UP_FIN : S_UP_RD;
                  end else if (held_ff != '0 && !(req_distance > root_ff[EW-1:ID_WIDTH])) begin
                     pos_in   = '0;
                     kept_in  = 1'b1;
                     state_in = S_DN_RDL;
                  end else begin
                     state_in = S_RESP;
                  end
               end else begin
                  state_in = (held_ff == '0) ? S_RESP : S_DR_RD;
               end
            end
         end
         S_UP_RD: begin
            mem_re    = 1'b1;
            mem_raddr = parent_idx;
            state_in  = S_UP_CMP;
         end
         S_UP_CMP: begin
            mem_we = 1'b1;
            if (!(x_d < rd_d)) begin
               mem_wdata = mem_rdata;
               pos_in    = parent_idx;
               state_in  = (parent_idx == '0) ? S_UP_FIN : S_UP_RD;
            end else begin
               state_in  = S_RESP;
            end
         end
         S_UP_FIN: begin
            mem_we   = 1'b1;
            state_in = S_RESP;
         end
         S_DN_RDL: begin
            if (has_left) begin
               mem_re    = 1'b1;
               mem_raddr = left_w[IDX_W-1:0];
               state_in  = S_DN_RDR;
            end else begin
               mem_we   = 1'b1;
               state_in = S_RESP;
            end
         end
         S_DN_RDR: begin
            left_in = mem_rdata;
            if (has_right) begin
               mem_re    = 1'b1;
               mem_raddr = right_w[IDX_W-1:0];
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            mem_we = 1'b1;
            if (x_d > child_d) begin
               state_in = S_RESP;
            end else begin
               mem_wdata = child_entry;
               pos_in    = child_idx;
               state_in  = S_DN_RDL;
            end
         end
         S_DR_RD: begin
            mem_re    = 1'b1;
            mem_raddr = held_dec[IDX_W-1:0];
            state_in  = S_DR_OUT;
         end
         S_DR_OUT: begin
            rsp_valid_in      = 1'b1;
            rsp_is_record_in  = 1'b1;
            rsp_entry_in      = mem_rdata;
            rsp_held_count_in = held_dec;
            rsp_last_in       = (held_dec == '0);
            held_in           = held_dec;
            state_in          = (held_dec == '0) ? S_IDLE : S_DR_RD;
         end
         S_RESP: begin
            // also covers a drain of an empty heap: all zero but last
            rsp_valid_in = 1'b1;
            rsp_entry_in = (held_ff != '0) ? root_ff : '0;
            rsp_kept_in  = kept_ff;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff            <= pos_in;
      x_ff              <= x_in;
      left_ff           <= left_in;
      kept_ff           <= kept_in;
      rsp_is_record_ff  <= rsp_is_record_in;
      rsp_entry_ff      <= rsp_entry_in;
      rsp_kept_ff       <= rsp_kept_in;
      rsp_held_count_ff <= rsp_held_count_in;
      rsp_last_ff       <= rsp_last_in;
      // shadow copy of slot 0 for the drop test and the insert result
      if (mem_we && mem_waddr == '0) begin
         root_ff <= mem_wdata;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_record     = rsp_is_record_ff;
   assign rsp_out_distance  = rsp_entry_ff[EW-1:ID_WIDTH];
   assign rsp_out_record_id = rsp_entry_ff[ID_WIDTH-1:0];
   assign rsp_kept          = rsp_kept_ff;
   assign rsp_held_count    = rsp_held_count_ff;
   assign rsp_last          = rsp_last_ff;

   `BTKH_AST_SAME(a_no_rw_clash, mem_we, !mem_re, "heap memory read and written in one cycle")
   `BTKH_AST_SAME(a_held_bound, 1'b1, held_ff <= HELD_MAX, "held count beyond heap depth")
   `BTKH_AST_NEXT(a_accept_busy, accept, busy, "transaction accepted but block not busy")
   `BTKH_AST_SAME(a_drain_goes_on, rsp_valid_ff && !rsp_last_ff, busy && held_ff != '0,
                  "drain stopped before its last record")
   `BTKH_AST_SAME(a_record_not_kept, rsp_valid_ff && rsp_is_record_ff, !rsp_kept_ff,
                  "drained record flagged as kept")

endmodule
`default_nettype wire
